### hw/rtl/salc_pkg.sv
// salc_pkg: shared types and constants of the set-associative cache tag controller
// address split, request and response words, register indexes; no dependencies
`default_nettype none

package salc_pkg;

	localparam int WAYS_DEFAULT = 4;
	localparam int SETS         = 64;
	localparam int LINE_BYTES   = 64;
	localparam int ADDR_BITS    = 32;

	localparam int OFF_BITS  = $clog2(LINE_BYTES);
	localparam int SET_BITS  = $clog2(SETS);
	localparam int TAG_WIDTH = ADDR_BITS - OFF_BITS - SET_BITS;

	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = 1;

	localparam logic [CFG_IDX_BITS-1:0] REG_WB_MODE = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_WA_MODE = 1'd1;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [31:0] address;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [1:0]  way;
		logic        allocated;
		logic        evicted;
		logic [19:0] victim_tag;
		logic        mem_write;
	} rsp_t;

	typedef struct packed {
		logic wb_en;
		logic wa_en;
	} mode_t;

endpackage

`default_nettype wire

### hw/rtl/set_assoc_cache_lru_tag_controller_top.sv
// set_assoc_cache_lru_tag_controller_top: cache tag controller, true lru, wb/wt, wa/nwa
// a request is accepted only in idle, once the last has left lookup; its set row is then
// read from the tag and state memories into registers, and written back when the lookup
// advances, before the next read; the response word is registered as the lookup advances
// reset: modes go to write-back and write-allocate; a clearing pass over all SETS (64)
// rows rewrites the state memory, requests are stalled until it ends
`default_nettype none

module set_assoc_cache_lru_tag_controller_top #(
	parameter int WAYS = salc_pkg::WAYS_DEFAULT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_stall,
	input  wire salc_pkg::req_t                     req,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_stall,
	output salc_pkg::rsp_t                          rsp,
	input  wire logic                               cfg_we,
	input  wire logic [salc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [salc_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

	localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SET_W  = salc_pkg::SET_BITS;
	localparam int TAG_W  = salc_pkg::TAG_WIDTH;

	typedef struct packed {
		logic [WAYS-1:0]             valid;
		logic [WAYS-1:0]             dirty;
		logic [WAYS-1:0][RANK_W-1:0] rank;
	} meta_row_t;

	typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	state_t          state_q;
	logic [SET_W-1:0] clr_idx_q;
	salc_pkg::mode_t mode_q;
	salc_pkg::rsp_t  rsp_q;
	logic            rsp_valid_q;

	logic             write_s1;
	logic [SET_W-1:0] set_s1;
	logic [TAG_W-1:0] tag_s1;

	meta_row_t meta_mem [salc_pkg::SETS];
	tag_row_t  tag_mem  [salc_pkg::SETS];
	meta_row_t meta_rd_q;
	tag_row_t  tag_rd_q;

	logic             accept;
	logic             advance;
	logic [SET_W-1:0] req_set;
	meta_row_t        clr_row;
	meta_row_t        upd_row;
	tag_row_t         upd_tag_row;
	logic             meta_we;
	logic [SET_W-1:0] meta_waddr;
	meta_row_t        meta_wrow;

	salc_pkg::rsp_t    lk_rsp;
	logic              lk_alloc;
	logic [RANK_W-1:0] lk_sel;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign advance   = (state_q == ST_LOOKUP) && (!rsp_valid_q || !rsp_stall);
	assign req_set   = req.address[salc_pkg::OFF_BITS +: SET_W];
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	salc_lookup #(
		.WAYS(WAYS)
	) u_lookup (
		.is_write (write_s1),
		.tag      (tag_s1),
		.mode     (mode_q),
		.tag_row  (tag_rd_q),
		.valid    (meta_rd_q.valid),
		.dirty    (meta_rd_q.dirty),
		.rank     (meta_rd_q.rank),
		.rsp      (lk_rsp),
		.alloc    (lk_alloc),
		.sel      (lk_sel),
		.new_valid(upd_row.valid),
		.new_dirty(upd_row.dirty),
		.new_rank (upd_row.rank)
	);

	always_comb begin
		clr_row.valid = '0;
		clr_row.dirty = '0;
		for (int w = 0; w < WAYS; w++) begin
			clr_row.rank[w] = RANK_W'(w);
		end
		upd_tag_row = tag_rd_q;
		if (lk_alloc) begin
			upd_tag_row[lk_sel] = tag_s1;
		end
		meta_we    = (state_q == ST_CLEAR) || advance;
		meta_waddr = (state_q == ST_CLEAR) ? clr_idx_q : set_s1;
		meta_wrow  = (state_q == ST_CLEAR) ? clr_row : upd_row;
	end

	// set row memories, registered read
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_waddr] <= meta_wrow;
		end
		if (advance) begin
			tag_mem[set_s1] <= upd_tag_row;
		end
		if (accept) begin
			meta_rd_q <= meta_mem[req_set];
			tag_rd_q  <= tag_mem[req_set];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			write_s1 <= (req.req_type == salc_pkg::REQ_WRITE);
			set_s1   <= req_set;
			tag_s1   <= req.address[salc_pkg::OFF_BITS + SET_W +: TAG_W];
		end
		if (advance) begin
			rsp_q <= lk_rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + SET_W'(1);
					if (clr_idx_q == SET_W'(salc_pkg::SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (advance) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q.wb_en <= 1'b1;
			mode_q.wa_en <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				salc_pkg::REG_WB_MODE: mode_q.wb_en <= cfg_wdata[0];
				salc_pkg::REG_WA_MODE: mode_q.wa_en <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTH
	a_accept_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_LOOKUP))
		else $error("accepted word did not enter lookup");

	a_rsp_from_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_LOOKUP))
		else $error("response raised outside lookup");

	a_hit_not_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.hit && rsp_q.allocated))
		else $error("hit and allocate together");

	a_evict_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.evicted) |-> rsp_q.allocated)
		else $error("eviction without allocation");

	a_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.evicted) |-> (rsp_q.victim_tag == 20'd0))
		else $error("victim tag set without eviction");
`endif

endmodule

`default_nettype wire

### hw/rtl/salc_lookup.sv
// salc_lookup: tag compare, victim choice and lru/dirty/valid update for one set row
// uses salc_pkg for the response word, the mode flags and the tag width
`default_nettype none

module salc_lookup #(
	parameter int WAYS = salc_pkg::WAYS_DEFAULT
) (
	input  wire logic                                             is_write,
	input  wire logic [salc_pkg::TAG_WIDTH-1:0]                   tag,
	input  wire salc_pkg::mode_t                                  mode,
	input  wire logic [WAYS-1:0][salc_pkg::TAG_WIDTH-1:0]         tag_row,
	input  wire logic [WAYS-1:0]                                  valid,
	input  wire logic [WAYS-1:0]                                  dirty,
	input  wire logic [WAYS-1:0][((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] rank,
	output salc_pkg::rsp_t                                        rsp,
	output logic                                                  alloc,
	output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0]            sel,
	output logic [WAYS-1:0]                                       new_valid,
	output logic [WAYS-1:0]                                       new_dirty,
	output logic [WAYS-1:0][((WAYS > 1) ? $clog2(WAYS) : 1)-1:0]  new_rank
);

	localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic [WAYS-1:0]   hit_vec;
	logic              hit;
	logic              any_inv;
	logic [RANK_W-1:0] hit_sel;
	logic [RANK_W-1:0] inv_sel;
	logic [RANK_W-1:0] lru_sel;
	logic [RANK_W-1:0] old_rank;
	logic              no_alloc;
	logic              evict;

	always_comb begin
		hit_sel = '0;
		inv_sel = '0;
		lru_sel = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			hit_vec[w] = valid[w] && (tag_row[w] == tag);
			if (hit_vec[w]) begin
				hit_sel = RANK_W'(w);
			end
			if (!valid[w]) begin
				inv_sel = RANK_W'(w);
			end
			if (rank[w] == RANK_W'(WAYS - 1)) begin
				lru_sel = RANK_W'(w);
			end
		end
		hit      = |hit_vec;
		any_inv  = ~&valid;
		no_alloc = !hit && is_write && !mode.wa_en;
		alloc    = !hit && !no_alloc;
		evict    = alloc && !any_inv;
		sel      = hit ? hit_sel : (any_inv ? inv_sel : lru_sel);
		old_rank = rank[sel];

		new_valid = valid;
		new_dirty = dirty;
		new_rank  = rank;
		if (hit && is_write && mode.wb_en) begin
			new_dirty[sel] = 1'b1;
		end
		if (alloc) begin
			new_valid[sel] = 1'b1;
			new_dirty[sel] = is_write && mode.wb_en;
		end
		if (hit || alloc) begin
			for (int i = 0; i < WAYS; i++) begin
				if (rank[i] < old_rank) begin
					new_rank[i] = rank[i] + RANK_W'(1);
				end
			end
			new_rank[sel] = '0;
		end

		rsp.hit        = hit;
		rsp.way        = (hit || alloc) ? 2'(sel) : 2'd0;
		rsp.allocated  = alloc;
		rsp.evicted    = evict;
		rsp.victim_tag = evict ? 20'(tag_row[sel]) : 20'd0;
		rsp.mem_write  = (hit && is_write && !mode.wb_en) || no_alloc
			|| (evict && dirty[sel]) || (alloc && is_write && !mode.wb_en);
	end

endmodule

`default_nettype wire
